@@ rtl/stl_pkg.sv @@
// Shared types and constants for the servo and throttle slew limiter.
// Used by stl_cfg, stl_mul and servo_throttle_slew_limiter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 23;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SERVO_STEP    = 3'd0,
        REG_THROTTLE_STEP = 3'd1,
        REG_GIMBAL_LIMIT  = 3'd2,
        REG_THR_CEILING   = 3'd3,
        REG_PUMP_CUTOFF   = 3'd4,
        REG_SERVO_FREQ    = 3'd5,
        REG_PULSE_MIN     = 3'd6,
        REG_PULSE_MAX     = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [15:0] servo_step;
        logic [15:0] throttle_step;
        logic [15:0] gimbal_limit;
        logic [15:0] throttle_ceiling;
        logic [15:0] pump_cutoff;
        logic [8:0]  servo_freq;
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
    } cfg_t;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_SERVO_STEP    = 16'd3072;
    localparam logic [15:0] RST_THROTTLE_STEP = 16'd2621;
    localparam logic [15:0] RST_GIMBAL_LIMIT  = 16'd2560;
    localparam logic [15:0] RST_THR_CEILING   = 16'd35389;
    localparam logic [15:0] RST_PUMP_CUTOFF   = 16'd655;
    localparam logic [8:0]  RST_SERVO_FREQ    = 9'd333;
    localparam logic [11:0] RST_PULSE_MIN     = 12'd500;
    localparam logic [11:0] RST_PULSE_MAX     = 12'd2500;

    // Angle to pulse: floor(angle*500/3072) = floor(floor(angle*125/256)/3)
    localparam logic [11:0] CENTER_US   = 12'd1500;
    localparam logic [7:0]  ANGLE_SCALE = 8'd125;
    localparam logic [15:0] DIV3_RECIP  = 16'd43691;   // (2^17+1)/3
    localparam int          DIV3_SHIFT  = 17;
    localparam logic [17:0] DIV3_BIAS   = 18'd33000;   // 3 * DIV3_BIAS_Q
    localparam logic [15:0] DIV3_BIAS_Q = 16'd11000;

    // Pulse to duty: divide by one million through a reciprocal
    localparam logic [19:0] ONE_MILLION = 20'd1000000;
    localparam int          RECIP_SHIFT = 20;

endpackage

`default_nettype wire

@@ rtl/stl_cfg.sv @@
// Configuration register file for the slew limiter.
// Depends on stl_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module stl_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [2:0]        wr_index,
    input  wire logic [15:0]       wr_data,
    output stl_pkg::cfg_t          cfg
);
    import stl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.servo_step       <= RST_SERVO_STEP;
            cfg_reg.throttle_step    <= RST_THROTTLE_STEP;
            cfg_reg.gimbal_limit     <= RST_GIMBAL_LIMIT;
            cfg_reg.throttle_ceiling <= RST_THR_CEILING;
            cfg_reg.pump_cutoff      <= RST_PUMP_CUTOFF;
            cfg_reg.servo_freq       <= RST_SERVO_FREQ;
            cfg_reg.pulse_min        <= RST_PULSE_MIN;
            cfg_reg.pulse_max        <= RST_PULSE_MAX;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_SERVO_STEP:    cfg_reg.servo_step       <= wr_data;
                REG_THROTTLE_STEP: cfg_reg.throttle_step    <= wr_data;
                REG_GIMBAL_LIMIT:  cfg_reg.gimbal_limit     <= wr_data;
                REG_THR_CEILING:   cfg_reg.throttle_ceiling <= wr_data;
                REG_PUMP_CUTOFF:   cfg_reg.pump_cutoff      <= wr_data;
                REG_SERVO_FREQ:    cfg_reg.servo_freq       <= wr_data[8:0];
                REG_PULSE_MIN:     cfg_reg.pulse_min        <= wr_data[11:0];
                REG_PULSE_MAX:     cfg_reg.pulse_max        <= wr_data[11:0];
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/stl_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on stl_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module stl_mul (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [stl_pkg::MUL_W-1:0]   a,
    input  wire logic signed [stl_pkg::MUL_W-1:0]   b,
    output logic signed [stl_pkg::PROD_W-1:0]       prod
);
    import stl_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // Hold the product until the next issue
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/servo_throttle_slew_limiter.sv @@
// One item is in work at a time, and the single shared multiplier works both servo
// channels in turn; an item also waits in its last state until the result slot is free.
// A finished result waits in the output registers while the next item is taken.
// Reset (asynchronous, active low) clears the held angles and throttle, loads the
// register defaults and drops res_valid.
`timescale 1ns / 1ps
`default_nettype none

module servo_throttle_slew_limiter #(
    parameter int DUTY_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire logic               cmd,
    input  wire logic signed [16:0] pitch_target,
    input  wire logic signed [16:0] yaw_target,
    input  wire logic signed [16:0] throttle_target,
    // result channel
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic signed [16:0]      pitch_angle,
    output logic signed [16:0]      yaw_angle,
    output logic [15:0]             throttle_level,
    output logic [11:0]             pitch_pulse_us,
    output logic [11:0]             yaw_pulse_us,
    output logic [15:0]             pitch_compare,
    output logic [15:0]             yaw_compare,
    output logic [15:0]             pump_compare,
    // configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import stl_pkg::*;

    localparam logic [63:0] DUTY_RECIP_W = (64'd1 << (RECIP_SHIFT + DUTY_BITS)) / 64'd1000000;
    localparam logic [63:0] DUTY_FULL_W  = (64'd1 << DUTY_BITS) - 64'd1;
    localparam logic [21:0] DUTY_RECIP   = DUTY_RECIP_W[21:0];
    localparam logic [22:0] DUTY_FULL    = DUTY_FULL_W[22:0];

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_DELTA = 11'b000_0000_0010,
        ST_SUM   = 11'b000_0000_0100,
        ST_SCALE = 11'b000_0000_1000,
        ST_DIV3  = 11'b000_0001_0000,
        ST_PULSE = 11'b000_0010_0000,
        ST_FREQ  = 11'b000_0100_0000,
        ST_RECIP = 11'b000_1000_0000,
        ST_BACK  = 11'b001_0000_0000,
        ST_FIX   = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    function automatic logic signed [18:0] clamp19(
        input logic signed [18:0] v,
        input logic signed [18:0] lo,
        input logic signed [18:0] hi
    );
        logic signed [18:0] r;
        r = v;
        if (r < lo) r = lo;
        if (r > hi) r = hi;
        return r;
    endfunction

    cfg_t                     cfg;
    state_t                   state_reg, state_next;
    logic                     ch_reg;
    logic                     res_valid_reg;
    logic                     slot_free;

    logic                     estop_reg;
    logic signed [16:0]       pitch_tgt_reg, yaw_tgt_reg, thr_tgt_reg;
    logic signed [17:0]       dp_reg, dy_reg, dt_reg;
    logic signed [16:0]       pitch_now_reg, yaw_now_reg;
    logic [15:0]              thr_now_reg;
    logic [11:0]              pitch_width_reg, yaw_width_reg;
    logic [20:0]              z_reg;
    logic [21:0]              q0_reg;
    logic [15:0]              pitch_cmp_reg, yaw_cmp_reg;

    logic signed [16:0]       pitch_angle_reg, yaw_angle_reg;
    logic [15:0]              throttle_level_reg, pump_cmp_reg;
    logic [11:0]              pitch_pulse_reg, yaw_pulse_reg;
    logic [15:0]              pitch_cmp_out_reg, yaw_cmp_out_reg;

    logic                     mul_en;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [18:0]       step_s, tstep_s, lim_s, ceil_s;
    logic signed [18:0]       dp_c, dy_c, dt_c;
    logic signed [18:0]       pn_c, yn_c, tn_c;
    logic signed [16:0]       angle_sel;
    logic [11:0]              us_sel;
    logic signed [16:0]       scaled;
    logic [17:0]              div3_in;
    logic signed [15:0]       us_raw;
    logic signed [15:0]       us_lo, us_hi;
    logic [11:0]              us_clamped;
    logic [PROD_W-1:0]        z_shift, rem;
    logic [22:0]              duty_wide;

    stl_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    stl_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign cfg_ready = 1'b1;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign slot_free = !res_valid_reg || res_ready;

    // Slew limits, zero-extended into one working width
    assign step_s  = $signed({3'b000, cfg.servo_step});
    assign tstep_s = $signed({3'b000, cfg.throttle_step});
    assign lim_s   = $signed({3'b000, cfg.gimbal_limit});
    assign ceil_s  = $signed({3'b000, cfg.throttle_ceiling});

    assign dp_c = clamp19($signed({{2{pitch_tgt_reg[16]}}, pitch_tgt_reg})
                          - $signed({{2{pitch_now_reg[16]}}, pitch_now_reg}),
                          -step_s, step_s);
    assign dy_c = clamp19($signed({{2{yaw_tgt_reg[16]}}, yaw_tgt_reg})
                          - $signed({{2{yaw_now_reg[16]}}, yaw_now_reg}),
                          -step_s, step_s);
    assign dt_c = clamp19($signed({{2{thr_tgt_reg[16]}}, thr_tgt_reg})
                          - $signed({3'b000, thr_now_reg}),
                          -tstep_s, tstep_s);

    assign pn_c = clamp19($signed({{2{pitch_now_reg[16]}}, pitch_now_reg})
                          + $signed({dp_reg[17], dp_reg}), -lim_s, lim_s);
    assign yn_c = clamp19($signed({{2{yaw_now_reg[16]}}, yaw_now_reg})
                          + $signed({dy_reg[17], dy_reg}), -lim_s, lim_s);
    assign tn_c = clamp19($signed({3'b000, thr_now_reg})
                          + $signed({dt_reg[17], dt_reg}), 19'sd0, ceil_s);

    assign angle_sel = ch_reg ? yaw_now_reg : pitch_now_reg;
    assign us_sel    = ch_reg ? yaw_width_reg : pitch_width_reg;

    // floor(angle*125/256), biased positive for the divide by three
    assign scaled  = prod[24:8];
    assign div3_in = 18'($signed({scaled[16], scaled}) + $signed(DIV3_BIAS));

    assign us_raw = $signed({4'b0000, CENTER_US})
                    + $signed({1'b0, prod[DIV3_SHIFT+14:DIV3_SHIFT]})
                    - $signed(DIV3_BIAS_Q);
    // Raise to the minimum first, then lower to the maximum
    assign us_lo  = (us_raw < $signed({4'b0000, cfg.pulse_min}))
                    ? $signed({4'b0000, cfg.pulse_min}) : us_raw;
    assign us_hi  = (us_lo > $signed({4'b0000, cfg.pulse_max}))
                    ? $signed({4'b0000, cfg.pulse_max}) : us_lo;
    assign us_clamped = us_hi[11:0];

    // The reciprocal estimate is at most one short; the remainder settles it
    assign z_shift = {{(PROD_W-21){1'b0}}, z_reg} << DUTY_BITS;
    assign rem     = z_shift - $unsigned(prod);

    always_comb
    begin
        if (z_reg >= 21'(ONE_MILLION))
        begin
            duty_wide = DUTY_FULL;
        end
        else if (rem >= PROD_W'(ONE_MILLION))
        begin
            duty_wide = {1'b0, q0_reg} + 23'd1;
        end
        else
        begin
            duty_wide = {1'b0, q0_reg};
        end
    end

    // Operand selection for the shared multiplier
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_SCALE:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(angle_sel);
                mul_b  = $signed({15'd0, ANGLE_SCALE});
            end
            ST_DIV3:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({5'd0, div3_in});
                mul_b  = $signed({7'd0, DIV3_RECIP});
            end
            ST_FREQ:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({11'd0, us_sel});
                mul_b  = $signed({14'd0, cfg.servo_freq});
            end
            ST_RECIP:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, prod[20:0]});
                mul_b  = $signed({1'b0, DUTY_RECIP});
            end
            ST_BACK:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({1'b0, prod[RECIP_SHIFT+21:RECIP_SHIFT]});
                mul_b  = $signed({3'b000, ONE_MILLION});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (cmd_valid) state_next = ST_DELTA;
            ST_DELTA: state_next = estop_reg ? ST_FREQ : ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV3;
            ST_DIV3:  state_next = ST_PULSE;
            ST_PULSE: state_next = ST_FREQ;
            ST_FREQ:  state_next = ST_RECIP;
            ST_RECIP: state_next = ST_BACK;
            ST_BACK:  state_next = ST_FIX;
            ST_FIX:
            begin
                if (ch_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = estop_reg ? ST_FREQ : ST_SCALE;
                end
            end
            ST_DONE:  if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            pitch_now_reg <= '0;
            yaw_now_reg   <= '0;
            thr_now_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DELTA)
            begin
                ch_reg <= 1'b0;
                if (estop_reg)
                begin
                    pitch_now_reg <= '0;
                    yaw_now_reg   <= '0;
                    thr_now_reg   <= '0;
                end
            end
            if (state_reg == ST_SUM)
            begin
                pitch_now_reg <= pn_c[16:0];
                yaw_now_reg   <= yn_c[16:0];
                thr_now_reg   <= tn_c[15:0];
            end
            if (state_reg == ST_FIX)
            begin
                ch_reg <= 1'b1;
            end
            if (state_reg == ST_DONE && slot_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            estop_reg     <= cmd;
            pitch_tgt_reg <= pitch_target;
            yaw_tgt_reg   <= yaw_target;
            thr_tgt_reg   <= throttle_target;
        end
        if (state_reg == ST_DELTA)
        begin
            dp_reg <= dp_c[17:0];
            dy_reg <= dy_c[17:0];
            dt_reg <= dt_c[17:0];
            if (estop_reg)
            begin
                pitch_width_reg <= CENTER_US;
                yaw_width_reg   <= CENTER_US;
            end
        end
        if (state_reg == ST_PULSE)
        begin
            if (ch_reg)
            begin
                yaw_width_reg <= us_clamped;
            end
            else
            begin
                pitch_width_reg <= us_clamped;
            end
        end
        if (state_reg == ST_RECIP)
        begin
            z_reg <= prod[20:0];
        end
        if (state_reg == ST_BACK)
        begin
            q0_reg <= prod[RECIP_SHIFT+21:RECIP_SHIFT];
        end
        if (state_reg == ST_FIX)
        begin
            if (ch_reg)
            begin
                yaw_cmp_reg <= duty_wide[15:0];
            end
            else
            begin
                pitch_cmp_reg <= duty_wide[15:0];
            end
        end
        if (state_reg == ST_DONE && slot_free)
        begin
            pitch_angle_reg    <= pitch_now_reg;
            yaw_angle_reg      <= yaw_now_reg;
            throttle_level_reg <= thr_now_reg;
            pitch_pulse_reg    <= pitch_width_reg;
            yaw_pulse_reg      <= yaw_width_reg;
            pitch_cmp_out_reg  <= pitch_cmp_reg;
            yaw_cmp_out_reg    <= yaw_cmp_reg;
            pump_cmp_reg       <= (thr_now_reg < cfg.pump_cutoff) ? 16'd0 : thr_now_reg;
        end
    end

    assign res_valid      = res_valid_reg;
    assign pitch_angle    = pitch_angle_reg;
    assign yaw_angle      = yaw_angle_reg;
    assign throttle_level = throttle_level_reg;
    assign pitch_pulse_us = pitch_pulse_reg;
    assign yaw_pulse_us   = yaw_pulse_reg;
    assign pitch_compare  = pitch_cmp_out_reg;
    assign yaw_compare    = yaw_cmp_out_reg;
    assign pump_compare   = pump_cmp_reg;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg == ST_DELTA))
        else $error("accepted item did not start the slew step");

    a_delta_first_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELTA) |=> !ch_reg)
        else $error("channel index not cleared at item start");

    a_estop_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELTA && estop_reg) |=>
        (pitch_now_reg == 17'sd0 && yaw_now_reg == 17'sd0 && thr_now_reg == 16'd0))
        else $error("emergency stop left held state non-zero");

    a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX) |-> (duty_wide <= DUTY_FULL))
        else $error("duty correction exceeded full scale");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && slot_free) |=> (res_valid && cmd_ready))
        else $error("finished item not presented");
`endif

endmodule

`default_nettype wire

@@ dv/stl_slew_checker.sv @@
// Checker for the servo and throttle slew limiter: watches the command, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on stl_pkg for the register indexes and reset values.
`timescale 1ns / 1ps

module stl_slew_checker #(
    parameter int DUTY_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire logic               cmd_ready,
    input  wire logic               cmd,
    input  wire logic signed [16:0] pitch_target,
    input  wire logic signed [16:0] yaw_target,
    input  wire logic signed [16:0] throttle_target,
    input  wire logic               res_valid,
    input  wire logic               res_ready,
    input  wire logic signed [16:0] pitch_angle,
    input  wire logic signed [16:0] yaw_angle,
    input  wire logic [15:0]        throttle_level,
    input  wire logic [11:0]        pitch_pulse_us,
    input  wire logic [11:0]        yaw_pulse_us,
    input  wire logic [15:0]        pitch_compare,
    input  wire logic [15:0]        yaw_compare,
    input  wire logic [15:0]        pump_compare,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output int                      faults,
    output int                      results_done,
    output int                      backlog
);

    import stl_pkg::*;

    localparam int              PULSE_NUM    = 500;
    localparam int              PULSE_DEN    = 3072;
    localparam int              CENTRE_PULSE = 1500;
    localparam longint unsigned MICROS_PER_S = 64'd1000000;

    typedef struct packed {
        logic [16:0] pitch;
        logic [16:0] yaw;
        logic [15:0] throttle;
        logic [11:0] pitch_width;
        logic [11:0] yaw_width;
        logic [15:0] pitch_cmp;
        logic [15:0] yaw_cmp;
        logic [15:0] pump;
    } servo_reading_t;

    servo_reading_t expected_readings[$];

    int lim_servo_step, lim_thr_step, lim_gimbal, lim_ceiling;
    int lim_cutoff, lim_freq, lim_pmin, lim_pmax;
    int held_pitch, held_yaw, held_throttle;
    int fault_n, done_n;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    function automatic int slew_angle(input int held, input int target);
        int delta;
        delta = clamp_int(target - held, -lim_servo_step, lim_servo_step);
        return clamp_int(held + delta, -lim_gimbal, lim_gimbal);
    endfunction

    // floor(angle*500/3072) with rounding towards minus infinity
    function automatic int pulse_of(input int angle);
        int p, q, us;
        p = angle * PULSE_NUM;
        if (p >= 0) q = p / PULSE_DEN;
        else q = -((-p + PULSE_DEN - 1) / PULSE_DEN);
        us = CENTRE_PULSE + q;
        if (us < lim_pmin) us = lim_pmin;
        if (us > lim_pmax) us = lim_pmax;
        if (us < 0) us = 0;
        return us;
    endfunction

    function automatic logic [15:0] duty_of(input int us);
        longint unsigned full, wide_us, wide_f, d;
        full    = (64'd1 << DUTY_BITS) - 64'd1;
        wide_us = us;
        wide_f  = lim_freq;
        d = ((wide_us * wide_f) << DUTY_BITS) / MICROS_PER_S;
        if (d > full) d = full;
        return d[15:0];
    endfunction

    // Advance the held state by one command and return the reading it gives
    function automatic servo_reading_t advance_hold(input logic stop,
                                                    input logic signed [16:0] tp,
                                                    input logic signed [16:0] ty,
                                                    input logic signed [16:0] tt);
        servo_reading_t r;
        int pus, yus, pump, th;
        if (stop) begin
            held_pitch    = 0;
            held_yaw      = 0;
            held_throttle = 0;
            pus  = CENTRE_PULSE;
            yus  = CENTRE_PULSE;
            pump = 0;
        end
        else begin
            held_pitch = slew_angle(held_pitch, tp);
            held_yaw   = slew_angle(held_yaw, ty);
            th = held_throttle
                 + clamp_int(int'(tt) - held_throttle, -lim_thr_step, lim_thr_step);
            held_throttle = clamp_int(th, 0, lim_ceiling);
            pus  = pulse_of(held_pitch);
            yus  = pulse_of(held_yaw);
            pump = (held_throttle < lim_cutoff) ? 0 : held_throttle;
        end
        r.pitch       = 17'(held_pitch);
        r.yaw         = 17'(held_yaw);
        r.throttle    = 16'(held_throttle);
        r.pitch_width = 12'(pus);
        r.yaw_width   = 12'(yus);
        r.pitch_cmp   = duty_of(pus);
        r.yaw_cmp     = duty_of(yus);
        r.pump        = 16'(pump);
        return r;
    endfunction

    task automatic log_fault(input string msg);
        fault_n++;
        if (fault_n <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string label, input logic [16:0] want_v,
                               input logic [16:0] got_v);
        if (got_v !== want_v)
            log_fault($sformatf("%s expected 0x%05h got 0x%05h", label, want_v, got_v));
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        servo_reading_t want;
        if (!rst_n) begin
            lim_servo_step = RST_SERVO_STEP;
            lim_thr_step   = RST_THROTTLE_STEP;
            lim_gimbal     = RST_GIMBAL_LIMIT;
            lim_ceiling    = RST_THR_CEILING;
            lim_cutoff     = RST_PUMP_CUTOFF;
            lim_freq       = RST_SERVO_FREQ;
            lim_pmin       = RST_PULSE_MIN;
            lim_pmax       = RST_PULSE_MAX;
            held_pitch     = 0;
            held_yaw       = 0;
            held_throttle  = 0;
            fault_n        = 0;
            done_n         = 0;
            expected_readings.delete();
            faults       <= 0;
            results_done <= 0;
            backlog      <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_SERVO_STEP:    lim_servo_step = cfg_data;
                    REG_THROTTLE_STEP: lim_thr_step   = cfg_data;
                    REG_GIMBAL_LIMIT:  lim_gimbal     = cfg_data;
                    REG_THR_CEILING:   lim_ceiling    = cfg_data;
                    REG_PUMP_CUTOFF:   lim_cutoff     = cfg_data;
                    REG_SERVO_FREQ:    lim_freq       = cfg_data[8:0];
                    REG_PULSE_MIN:     lim_pmin       = cfg_data[11:0];
                    REG_PULSE_MAX:     lim_pmax       = cfg_data[11:0];
                    default:           ;
                endcase
            end
            // retire the result first: it belongs to an item older than any taken now
            if (res_valid && res_ready) begin
                done_n++;
                if (expected_readings.size() == 0) begin
                    log_fault("result item with nothing expected");
                end
                else begin
                    want = expected_readings.pop_front();
                    check_field("pitch_angle", want.pitch, pitch_angle);
                    check_field("yaw_angle", want.yaw, yaw_angle);
                    check_field("throttle_level", want.throttle, throttle_level);
                    check_field("pitch_pulse_us", want.pitch_width, pitch_pulse_us);
                    check_field("yaw_pulse_us", want.yaw_width, yaw_pulse_us);
                    check_field("pitch_compare", want.pitch_cmp, pitch_compare);
                    check_field("yaw_compare", want.yaw_cmp, yaw_compare);
                    check_field("pump_compare", want.pump, pump_compare);
                end
            end
            if (cmd_valid && cmd_ready)
                expected_readings.push_back(
                    advance_hold(cmd, pitch_target, yaw_target, throttle_target));
            faults       <= fault_n;
            results_done <= done_n;
            backlog      <= expected_readings.size();
        end
    end

endmodule

@@ dv/servo_throttle_slew_limiter_tb.sv @@
// Testbench top for the servo and throttle slew limiter: drives commands and
// register writes with bursty timing, stalls the result side and gives the verdict.
// Depends on stl_pkg, the block itself and stl_slew_checker.
`timescale 1ns / 1ps

module servo_throttle_slew_limiter_tb;

    import stl_pkg::*;

    localparam int DUTY_BITS   = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_LONG
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cmd_valid = 1'b0;
    logic               cmd = 1'b0;
    logic signed [16:0] pitch_target = '0;
    logic signed [16:0] yaw_target = '0;
    logic signed [16:0] throttle_target = '0;
    logic               res_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    logic               cmd_ready, res_valid, cfg_ready;
    logic signed [16:0] pitch_angle, yaw_angle;
    logic [15:0]        throttle_level, pitch_compare, yaw_compare, pump_compare;
    logic [11:0]        pitch_pulse_us, yaw_pulse_us;

    int faults, results_done, backlog;
    int items_sent = 0;
    int burst_left = 0;
    int cycle_count = 0;

    rx_mode_t   rx_mode = RX_ALWAYS;
    logic [5:0] rx_tick = '0;

    servo_throttle_slew_limiter #(.DUTY_BITS(DUTY_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .pitch_target(pitch_target), .yaw_target(yaw_target),
        .throttle_target(throttle_target),
        .res_valid(res_valid), .res_ready(res_ready),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
        .throttle_level(throttle_level),
        .pitch_pulse_us(pitch_pulse_us), .yaw_pulse_us(yaw_pulse_us),
        .pitch_compare(pitch_compare), .yaw_compare(yaw_compare),
        .pump_compare(pump_compare),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    stl_slew_checker #(.DUTY_BITS(DUTY_BITS)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .pitch_target(pitch_target), .yaw_target(yaw_target),
        .throttle_target(throttle_target),
        .res_valid(res_valid), .res_ready(res_ready),
        .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
        .throttle_level(throttle_level),
        .pitch_pulse_us(pitch_pulse_us), .yaw_pulse_us(yaw_pulse_us),
        .pitch_compare(pitch_compare), .yaw_compare(yaw_compare),
        .pump_compare(pump_compare),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .faults(faults), .results_done(results_done), .backlog(backlog)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: switch stall pattern each time the 6-bit tick counter wraps
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_tick == 6'd0) rx_mode <= rx_mode_t'($urandom_range(3));
        case (rx_mode)
            RX_ALWAYS: res_ready <= 1'b1;
            RX_COIN:   res_ready <= ($urandom_range(1) != 0);
            RX_SPARSE: res_ready <= (rx_tick[2:0] == 3'd0);
            default:   res_ready <= (rx_tick[4:0] > 5'd23);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Raise valid and hold it until the item is taken; gaps fall between bursts
    task automatic send_item(input logic stop, input int p_t, input int y_t, input int t_t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        cmd_valid       <= 1'b1;
        cmd             <= stop;
        pitch_target    <= 17'(p_t);
        yaw_target      <= 17'(y_t);
        throttle_target <= 17'(t_t);
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        items_sent++;
        burst_left--;
    endtask

    task automatic put_reg(input reg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic write_limits(input logic [15:0] s_step, input logic [15:0] t_step,
                                input logic [15:0] gimbal, input logic [15:0] ceiling,
                                input logic [15:0] cutoff, input logic [15:0] freq,
                                input logic [15:0] pmin, input logic [15:0] pmax);
        put_reg(REG_SERVO_STEP, s_step);
        put_reg(REG_THROTTLE_STEP, t_step);
        put_reg(REG_GIMBAL_LIMIT, gimbal);
        put_reg(REG_THR_CEILING, ceiling);
        put_reg(REG_PUMP_CUTOFF, cutoff);
        put_reg(REG_SERVO_FREQ, freq);
        put_reg(REG_PULSE_MIN, pmin);
        put_reg(REG_PULSE_MAX, pmax);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_random_limits();
        logic [15:0] s_step, t_step, gimbal, ceiling, cutoff, freq, pmin, pmax;
        s_step  = 16'(($urandom_range(3) == 0) ? $urandom_range(600)
                                               : $urandom_range(46080));
        t_step  = 16'(($urandom_range(3) == 0) ? $urandom_range(1000)
                                               : $urandom_range(65535));
        gimbal  = 16'($urandom_range(46080));
        ceiling = 16'($urandom_range(65535));
        cutoff  = 16'(($urandom_range(4) == 0) ? $urandom_range(65535)
                                               : $urandom_range(ceiling));
        freq    = 16'($urandom_range(50, 400));
        pmin    = 16'($urandom_range(2000));
        pmax    = 16'($urandom_range(pmin, 4000));
        write_limits(s_step, t_step, gimbal, ceiling, cutoff, freq, pmin, pmax);
    endtask

    function automatic int pick_angle();
        case ($urandom_range(9))
            0:       return ($urandom_range(1) != 0) ? 46080 : -46080;
            1:       return int'($urandom & 32'h1FFFF);
            2, 3:    return int'($urandom_range(8192)) - 4096;
            default: return int'($urandom_range(92160)) - 46080;
        endcase
    endfunction

    function automatic int pick_throttle();
        case ($urandom_range(9))
            0:       return ($urandom_range(1) != 0) ? 65535 : -65535;
            1:       return int'($urandom & 32'h1FFFF);
            2:       return int'($urandom_range(1400));
            default: return int'($urandom_range(131070)) - 65535;
        endcase
    endfunction

    // Hold the same targets for a run of items so the slew reaches the clamps
    task automatic run_phase(input int count);
        int hold_left, tp, ty, tt;
        logic stop;
        hold_left = 0;
        tp = 0;
        ty = 0;
        tt = 0;
        repeat (count)
        begin
            if (hold_left <= 0)
            begin
                tp = pick_angle();
                ty = pick_angle();
                tt = pick_throttle();
                hold_left = ($urandom_range(2) == 0) ? $urandom_range(2, 10) : 1;
            end
            stop = ($urandom_range(29) == 0);
            send_item(stop, tp, ty, tt);
            hold_left--;
        end
    endtask

    // Drop valid and wait until every item has come back
    task automatic settle();
        cmd_valid <= 1'b0;
        while (results_done < items_sent) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: field extremes, both commands, pump cutoff edge
        send_item(1'b0, 0, 0, 0);
        repeat (4) send_item(1'b0, 46080, -46080, 65535);
        send_item(1'b0, 65535, -65536, 65535);
        send_item(1'b0, -65536, 65535, -65536);
        send_item(1'b0, -46080, 46080, -65535);
        send_item(1'b1, -1, -1, -1);
        send_item(1'b0, 0, 0, 654);
        send_item(1'b0, 0, 0, 655);
        send_item(1'b0, 1, -1, 656);
        send_item(1'b0, 3072, -3073, 35389);
        send_item(1'b1, 46080, 46080, 65535);
        send_item(1'b1, 0, 0, 0);
        send_item(1'b0, 2560, -2560, 35390);
        send_item(1'b0, -2561, 2561, 0);
        settle();

        write_limits(16'd46080, 16'd65535, 16'd46080, 16'd65535,
                     16'd65535, 16'd400, 16'd0, 16'd4000);
        run_phase(150);
        settle();
        write_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd50, 16'd0, 16'd0);
        run_phase(40);
        settle();
        // every register past its range: wide gimbal, top frequency, pulses pinned
        write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(100);
        settle();
        // crossed pulse limits and a stopped PWM clock
        write_limits(16'd3072, 16'd2621, 16'd46080, 16'd35389,
                     16'd655, 16'd0, 16'd2200, 16'd900);
        run_phase(100);
        for (phase = 0; phase < 8; phase++)
        begin
            settle();
            write_random_limits();
            run_phase(165);
        end
        settle();
        repeat (40) @(posedge clk);

        if (faults == 0 && backlog == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/stl_pkg.sv
rtl/stl_cfg.sv
rtl/stl_mul.sv
rtl/servo_throttle_slew_limiter.sv
dv/stl_slew_checker.sv
dv/servo_throttle_slew_limiter_tb.sv
